### src/dual_imu_cross_check_selector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual IMU selector
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef DUAL_IMU_CROSS_CHECK_SELECTOR_CORE_MACROS_SVH
`define DUAL_IMU_CROSS_CHECK_SELECTOR_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DICS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define DICS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dics_pkg.sv
// ----------------------------------------------------------------------------
// Dual IMU selector package
// Widths, register indexes and shared types of the selector.
// ----------------------------------------------------------------------------
package dics_pkg;

    localparam int AXIS_BITS = 16;
    localparam int TIME_BITS = 32;
    localparam int FIELD_BITS = 48;
    localparam int DIFF_BITS = AXIS_BITS + 1;
    localparam int SQ_BITS = 2 * DIFF_BITS + 2;
    localparam int ROOT_BITS = SQ_BITS / 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_ACCEL_THR = 3'd0,
        REG_GYRO_THR = 3'd1,
        REG_INTERVAL = 3'd2,
        REG_FAIL_LIMIT = 3'd3,
        REG_GRAVITY = 3'd4,
        REG_PRI_PRESENT = 3'd5,
        REG_SEC_PRESENT = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] pa;
        logic [FIELD_BITS-1:0] pg;
        logic [FIELD_BITS-1:0] sa;
        logic [FIELD_BITS-1:0] sg;
        logic p_ok;
        logic s_ok;
        logic p_h;
        logic s_h;
        logic any_present;
        logic [TIME_BITS-1:0] now;
    } item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] accel;
        logic [FIELD_BITS-1:0] gyro;
        logic healthy;
        logic on_primary;
        logic checked;
        logic disagree;
        logic reselected;
        logic [7:0] count;
    } result_t;

    function automatic logic signed [AXIS_BITS-1:0] axis_of(
        input logic [FIELD_BITS-1:0] packed_v,
        input int unsigned i
    );
        return packed_v[AXIS_BITS*i +: AXIS_BITS];
    endfunction

endpackage

### src/dual_imu_cross_check_selector_core.sv
// ----------------------------------------------------------------------------
// Dual IMU cross-check selector core
// A checked sample pair runs through the one-multiplier sum-of-squares
// sequencer and, when the gravity test runs, the two-bit-per-cycle square
// root. Two requests queue in front. One request is processed at a time.
// Reset is synchronous and active low; configuration, control and held
// sample registers return to defaults; queue storage and data path do not.
// ----------------------------------------------------------------------------
`include "dual_imu_cross_check_selector_core_macros.svh"
module dual_imu_cross_check_selector_core (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic [47:0] s_primary_accel,
    input  logic [47:0] s_primary_gyro,
    input  logic [47:0] s_secondary_accel,
    input  logic [47:0] s_secondary_gyro,
    input  logic s_primary_ok,
    input  logic s_primary_healthy,
    input  logic s_secondary_ok,
    input  logic s_secondary_healthy,
    input  logic [31:0] s_now_ms,
    output logic m_valid,
    input  logic m_ready,
    output logic [47:0] m_chosen_accel,
    output logic [47:0] m_chosen_gyro,
    output logic m_healthy,
    output logic m_on_primary,
    output logic m_checked,
    output logic m_disagree,
    output logic m_reselected,
    output logic [7:0] m_disagree_count
);
    import dics_pkg::*;

    logic [15:0] accel_thr_reg, gyro_thr_reg, interval_reg, gravity_reg;
    logic [7:0] fail_limit_reg;
    logic pri_reg, sec_reg;
    item_t in_item, q_item;
    result_t res;
    logic q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_thr_reg <= 16'd512;
            gyro_thr_reg <= 16'd160;
            interval_reg <= 16'd100;
            fail_limit_reg <= 8'd10;
            gravity_reg <= 16'd2511;
            pri_reg <= 1'b1;
            sec_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ACCEL_THR: accel_thr_reg <= cfg_data;
                REG_GYRO_THR: gyro_thr_reg <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_FAIL_LIMIT: fail_limit_reg <= cfg_data[7:0];
                REG_GRAVITY: gravity_reg <= cfg_data;
                REG_PRI_PRESENT: pri_reg <= cfg_data[0];
                REG_SEC_PRESENT: sec_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item.pa = s_primary_accel;
        in_item.pg = s_primary_gyro;
        in_item.sa = s_secondary_accel;
        in_item.sg = s_secondary_gyro;
        in_item.p_ok = pri_reg && s_primary_ok;
        in_item.s_ok = sec_reg && s_secondary_ok;
        in_item.p_h = s_primary_healthy;
        in_item.s_h = s_secondary_healthy;
        in_item.any_present = pri_reg || sec_reg;
        in_item.now = TIME_BITS'(s_now_ms);
    end

    dics_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    dics_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .accel_thr(accel_thr_reg), .gyro_thr(gyro_thr_reg), .interval(interval_reg),
        .fail_limit(fail_limit_reg), .gravity(gravity_reg),
        .both_present(pri_reg && sec_reg),
        .res_valid(m_valid), .res_ready(m_ready), .res(res)
    );

    assign m_chosen_accel = res.accel;
    assign m_chosen_gyro = res.gyro;
    assign m_healthy = res.healthy;
    assign m_on_primary = res.on_primary;
    assign m_checked = res.checked;
    assign m_disagree = res.disagree;
    assign m_reselected = res.reselected;
    assign m_disagree_count = res.count;

    `DICS_ASSERT_IMP(a_resel_needs_disagree, m_valid && m_reselected, m_disagree && m_checked && m_disagree_count == 8'd0, "reselection without a failed check")
    `DICS_ASSERT_IMP(a_disagree_needs_check, m_valid && m_disagree, m_checked, "disagree flagged without a check")
    `DICS_ASSERT_NEXT(a_out_holds, m_valid && !m_ready, m_valid && $stable(m_chosen_accel) && $stable(m_disagree_count), "result changed while stalled")
endmodule

### src/dics_front.sv
// ----------------------------------------------------------------------------
// Dual IMU selector front end
// Accepts the qualified sample pairs and queues them.
// ----------------------------------------------------------------------------
module dics_front
    import dics_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  dics_pkg::item_t in_item,
    output logic q_valid,
    input  logic q_ready,
    output dics_pkg::item_t q_item
);
    item_t mem_reg [QUEUE_DEPTH];
    logic rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

### src/dics_back.sv
// ----------------------------------------------------------------------------
// Dual IMU selector back end
// Runs the cross check, the gravity test and the sample selection.
// ----------------------------------------------------------------------------
module dics_back
    import dics_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  dics_pkg::item_t q_item,
    input  logic [15:0] accel_thr,
    input  logic [15:0] gyro_thr,
    input  logic [15:0] interval,
    input  logic [7:0] fail_limit,
    input  logic [15:0] gravity,
    input  logic both_present,
    output logic res_valid,
    input  logic res_ready,
    output dics_pkg::result_t res
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQ = 7'b0000010,
        ST_SUM = 7'b0000100,
        ST_DEC = 7'b0001000,
        ST_ROOT = 7'b0010000,
        ST_SEL = 7'b0100000,
        ST_OUT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    item_t it_reg;
    logic [1:0] ax_reg;
    logic [2:0] ph_reg;
    logic [SQ_BITS-1:0] acc_reg;
    logic [SQ_BITS-1:0] sq_reg;
    logic [SQ_BITS-1:0] da_reg, dg_reg, ma_reg;
    logic [SQ_BITS-1:0] rx_reg, rr_reg, rb_reg;
    logic [ROOT_BITS-1:0] mag_p_reg;
    logic prefer_reg, do_check_reg, dis_reg, resel_reg;
    logic [7:0] run_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic [FIELD_BITS-1:0] held_a_reg, held_g_reg;
    logic held_h_reg;
    logic [TIME_BITS-1:0] elapsed;
    logic [FIELD_BITS-1:0] opa, opb;
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0] mag;
    logic [2*DIFF_BITS-1:0] sq_prod;
    logic [31:0] at2, gt2;
    logic [SQ_BITS-1:0] rsum;
    logic [ROOT_BITS-1:0] err_p, err_s, root_now;
    logic [8:0] run_inc;

    assign q_ready = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_OUT;
    assign elapsed = q_item.now - last_reg;
    assign at2 = accel_thr * accel_thr;
    assign gt2 = gyro_thr * gyro_thr;
    assign rsum = rr_reg + rb_reg;
    assign root_now = rr_reg[ROOT_BITS-1:0];
    assign err_p = (mag_p_reg >= ROOT_BITS'(gravity)) ? mag_p_reg - ROOT_BITS'(gravity)
                                                     : ROOT_BITS'(gravity) - mag_p_reg;
    assign err_s = (root_now >= ROOT_BITS'(gravity)) ? root_now - ROOT_BITS'(gravity)
                                                    : ROOT_BITS'(gravity) - root_now;
    assign run_inc = (run_reg == 8'hFF) ? 9'h0FF : {1'b0, run_reg} + 9'd1;

    // Phase 0 accel diff, 1 gyro diff, 2 primary magnitude, 3 secondary magnitude.
    always_comb begin
        case (ph_reg)
            3'd0: begin opa = it_reg.pa; opb = it_reg.sa; end
            3'd1: begin opa = it_reg.pg; opb = it_reg.sg; end
            3'd2: begin opa = it_reg.pa; opb = '0; end
            default: begin opa = it_reg.sa; opb = '0; end
        endcase
        diff = DIFF_BITS'(axis_of(opa, 32'(ax_reg))) - DIFF_BITS'(axis_of(opb, 32'(ax_reg)));
        mag = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
        sq_prod = mag * mag;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_SQ;
            ST_SQ: state_next = ST_SUM;
            ST_SUM: state_next = (ax_reg == 2'd2) ? ST_DEC : ST_SQ;
            ST_DEC: state_next = (ph_reg < 3'd2) ? ST_SQ : ST_ROOT;
            ST_ROOT: if (rb_reg == '0) state_next = ST_SQ;
            ST_SEL: state_next = ST_OUT;
            ST_OUT: if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                it_reg <= q_item;
                ax_reg <= 2'd0;
                ph_reg <= 3'd0;
                acc_reg <= '0;
                do_check_reg <= q_item.any_present && both_present && q_item.p_ok &&
                                q_item.s_ok && (elapsed >= TIME_BITS'(interval));
            end
            ST_SQ: sq_reg <= SQ_BITS'(sq_prod);
            ST_SUM: begin
                if (ax_reg == 2'd2) begin
                    case (ph_reg)
                        3'd0: da_reg <= acc_reg + sq_reg;
                        3'd1: dg_reg <= acc_reg + sq_reg;
                        default: ma_reg <= acc_reg + sq_reg;
                    endcase
                    acc_reg <= '0;
                    ax_reg <= 2'd0;
                end else begin
                    acc_reg <= acc_reg + sq_reg;
                    ax_reg <= ax_reg + 2'd1;
                end
            end
            ST_DEC: begin
                if (ph_reg < 3'd2) begin
                    ph_reg <= ph_reg + 3'd1;
                    rr_reg <= '0;
                    rb_reg <= '0;
                end else begin
                    rx_reg <= ma_reg;
                    rr_reg <= '0;
                    rb_reg <= SQ_BITS'(1) << (SQ_BITS - 2);
                end
            end
            ST_ROOT: begin
                if (rb_reg != '0) begin
                    if (rx_reg >= rsum) begin
                        rx_reg <= rx_reg - rsum;
                        rr_reg <= (rr_reg >> 1) + rb_reg;
                    end else begin
                        rr_reg <= rr_reg >> 1;
                    end
                    rb_reg <= rb_reg >> 2;
                end else begin
                    if (ph_reg == 3'd2) mag_p_reg <= root_now;
                    ph_reg <= ph_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // Control flow of the sequencer, including the early exits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prefer_reg <= 1'b1;
            run_reg <= 8'd0;
            last_reg <= '0;
            held_a_reg <= '0;
            held_g_reg <= '0;
            held_h_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                dis_reg <= 1'b0;
                resel_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && q_valid && !(q_item.any_present && both_present &&
                q_item.p_ok && q_item.s_ok && (elapsed >= TIME_BITS'(interval)))) begin
                state_reg <= ST_SEL;
            end
            if (state_reg == ST_DEC && ph_reg == 3'd1) begin
                last_reg <= it_reg.now;
                if (da_reg < SQ_BITS'(at2) && dg_reg < SQ_BITS'(gt2)) begin
                    run_reg <= 8'd0;
                    state_reg <= ST_SEL;
                end else begin
                    dis_reg <= 1'b1;
                    run_reg <= run_inc[7:0];
                    if (run_inc[7:0] <= fail_limit) state_reg <= ST_SEL;
                end
            end
            if (state_reg == ST_ROOT && rb_reg == '0 && ph_reg == 3'd3) begin
                prefer_reg <= err_p < err_s;
                resel_reg <= 1'b1;
                run_reg <= 8'd0;
                state_reg <= ST_SEL;
            end
            if (state_reg == ST_SEL && it_reg.any_present) begin
                if (prefer_reg && it_reg.p_ok) begin
                    held_a_reg <= it_reg.pa; held_g_reg <= it_reg.pg; held_h_reg <= it_reg.p_h;
                end else if (!prefer_reg && it_reg.s_ok) begin
                    held_a_reg <= it_reg.sa; held_g_reg <= it_reg.sg; held_h_reg <= it_reg.s_h;
                end else if (it_reg.p_ok) begin
                    held_a_reg <= it_reg.pa; held_g_reg <= it_reg.pg; held_h_reg <= it_reg.p_h;
                    prefer_reg <= 1'b1;
                end else if (it_reg.s_ok) begin
                    held_a_reg <= it_reg.sa; held_g_reg <= it_reg.sg; held_h_reg <= it_reg.s_h;
                    prefer_reg <= 1'b0;
                end else begin
                    held_h_reg <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        res.accel = held_a_reg;
        res.gyro = held_g_reg;
        res.healthy = held_h_reg;
        res.on_primary = prefer_reg;
        res.checked = do_check_reg;
        res.disagree = dis_reg;
        res.reselected = resel_reg;
        res.count = run_reg;
    end
endmodule

### dv/dual_imu_cross_check_selector_core_checker.sv
// ----------------------------------------------------------------------------
// Dual IMU selector result checker
// Watches the request and result channels, predicts each result with its own
// model of the selector, and counts fields that differ from the prediction.
// ----------------------------------------------------------------------------
module dual_imu_cross_check_selector_core_checker
    import dics_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic s_valid,
    input  logic s_ready,
    input  logic [47:0] s_primary_accel,
    input  logic [47:0] s_primary_gyro,
    input  logic [47:0] s_secondary_accel,
    input  logic [47:0] s_secondary_gyro,
    input  logic s_primary_ok,
    input  logic s_primary_healthy,
    input  logic s_secondary_ok,
    input  logic s_secondary_healthy,
    input  logic [31:0] s_now_ms,
    input  logic m_valid,
    input  logic m_ready,
    input  logic [47:0] m_chosen_accel,
    input  logic [47:0] m_chosen_gyro,
    input  logic m_healthy,
    input  logic m_on_primary,
    input  logic m_checked,
    input  logic m_disagree,
    input  logic m_reselected,
    input  logic [7:0] m_disagree_count,
    output int fail_count,
    output int pending_count,
    output int checks_seen,
    output int reselects_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] accel_thr, gyro_thr, interval_ms, gravity_mag;
    logic [7:0] fail_limit;
    logic pri_fitted, sec_fitted;
    logic prefer_pri;
    logic [7:0] miss_run;
    logic [31:0] last_ms;
    logic [47:0] hold_accel, hold_gyro;
    logic hold_healthy;
    result_t selection_q[$];

    assign pending_count = selection_q.size();

    function automatic logic [63:0] diff_energy(input logic [47:0] a, input logic [47:0] b);
        logic [63:0] s;
        logic signed [63:0] d;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            d = 64'(signed'(a[16*i +: 16])) - 64'(signed'(b[16*i +: 16]));
            s += 64'(d * d);
        end
        return s;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] gravity_gap(input logic [47:0] a);
        logic [63:0] m;
        m = floor_root(diff_energy(a, 48'd0));
        return (m >= gravity_mag) ? m - gravity_mag : 64'(gravity_mag) - m;
    endfunction

    task automatic predict_selection();
        logic p_ok, s_ok;
        result_t r;
        r = '0;
        p_ok = pri_fitted && s_primary_ok;
        s_ok = sec_fitted && s_secondary_ok;
        if (pri_fitted || sec_fitted) begin
            if (p_ok && s_ok && (s_now_ms - last_ms) >= 32'(interval_ms)) begin
                r.checked = 1;
                last_ms = s_now_ms;
                if (diff_energy(s_primary_accel, s_secondary_accel) < 64'(accel_thr) * accel_thr
                    && diff_energy(s_primary_gyro, s_secondary_gyro)
                       < 64'(gyro_thr) * gyro_thr) begin
                    miss_run = 0;
                end else begin
                    r.disagree = 1;
                    if (miss_run != 8'hff) miss_run++;
                    if (miss_run > fail_limit) begin
                        prefer_pri = gravity_gap(s_primary_accel)
                                     < gravity_gap(s_secondary_accel);
                        r.reselected = 1;
                        miss_run = 0;
                    end
                end
            end
            if (prefer_pri && p_ok || !s_ok && p_ok) begin
                hold_accel = s_primary_accel;
                hold_gyro = s_primary_gyro;
                hold_healthy = s_primary_healthy;
                prefer_pri = 1;
            end else if (s_ok) begin
                hold_accel = s_secondary_accel;
                hold_gyro = s_secondary_gyro;
                hold_healthy = s_secondary_healthy;
                prefer_pri = 0;
            end else begin
                hold_healthy = 0;
            end
        end
        r.accel = hold_accel;
        r.gyro = hold_gyro;
        r.healthy = hold_healthy;
        r.on_primary = prefer_pri;
        r.count = miss_run;
        checks_seen += r.checked;
        reselects_seen += r.reselected;
        selection_q.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t w;
        if (!aresetn) begin
            accel_thr <= 512; gyro_thr <= 160; interval_ms <= 100;
            fail_limit <= 10; gravity_mag <= 2511;
            pri_fitted <= 1; sec_fitted <= 1;
            prefer_pri = 1; miss_run = 0; last_ms = 0;
            hold_accel = 0; hold_gyro = 0; hold_healthy = 0;
            selection_q.delete();
            fail_count = 0; checks_seen = 0; reselects_seen = 0;
        end else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_ACCEL_THR: accel_thr <= cfg_data;
                    REG_GYRO_THR: gyro_thr <= cfg_data;
                    REG_INTERVAL: interval_ms <= cfg_data;
                    REG_FAIL_LIMIT: fail_limit <= cfg_data[7:0];
                    REG_GRAVITY: gravity_mag <= cfg_data;
                    REG_PRI_PRESENT: pri_fitted <= cfg_data[0];
                    REG_SEC_PRESENT: sec_fitted <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_selection();
            if (m_valid && m_ready) begin
                if (selection_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    w = selection_q.pop_front();
                    compare_field("chosen_accel", w.accel, m_chosen_accel);
                    compare_field("chosen_gyro", w.gyro, m_chosen_gyro);
                    compare_field("healthy", w.healthy, m_healthy);
                    compare_field("on_primary", w.on_primary, m_on_primary);
                    compare_field("checked", w.checked, m_checked);
                    compare_field("disagree", w.disagree, m_disagree);
                    compare_field("reselected", w.reselected, m_reselected);
                    compare_field("disagree_count", w.count, m_disagree_count);
                end
            end
        end
    end
endmodule

### dv/dual_imu_cross_check_selector_core_tb.sv
// ----------------------------------------------------------------------------
// Dual IMU selector testbench
// Drives directed and random sample pairs through several register settings,
// with bursty requests and a stalling receiver, and reports the verdict.
// ----------------------------------------------------------------------------
module dual_imu_cross_check_selector_core_tb;
    import dics_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 0, aresetn = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 0, s_ready;
    logic [47:0] s_primary_accel = '0, s_primary_gyro = '0;
    logic [47:0] s_secondary_accel = '0, s_secondary_gyro = '0;
    logic s_primary_ok = 0, s_primary_healthy = 0;
    logic s_secondary_ok = 0, s_secondary_healthy = 0;
    logic [31:0] s_now_ms = '0;
    logic m_valid, m_ready = 0;
    logic [47:0] m_chosen_accel, m_chosen_gyro;
    logic m_healthy, m_on_primary, m_checked, m_disagree, m_reselected;
    logic [7:0] m_disagree_count;
    int fail_count, pending_count, checks_seen, reselects_seen;
    int hold_off = 0;
    int sent = 0;
    logic [31:0] clock_ms = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    dual_imu_cross_check_selector_core u_dut (.*);
    dual_imu_cross_check_selector_core_checker u_checker (.*);

    initial begin
        #20ms;
        $display("dual_imu_cross_check_selector_core_tb NOT OK");
        $finish;
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) || sent[8];
        end
    end

    function automatic logic [47:0] near_axes(input logic [47:0] base, input int spread);
        logic [47:0] v;
        for (int i = 0; i < 3; i++)
            v[16*i +: 16] = base[16*i +: 16] + 16'($urandom_range(0, 2 * spread) - spread);
        return v;
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic send_pair(input logic [47:0] pa, pg, sa, sg,
                             input logic po, ph, so, sh, input logic [31:0] t);
        s_valid <= 1;
        s_primary_accel <= pa; s_primary_gyro <= pg;
        s_secondary_accel <= sa; s_secondary_gyro <= sg;
        s_primary_ok <= po; s_primary_healthy <= ph;
        s_secondary_ok <= so; s_secondary_healthy <= sh;
        s_now_ms <= t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic idle_gap();
        s_valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic random_pair(input int mode);
        logic [47:0] pa, pg, sa, sg;
        pa = {$urandom, $urandom};
        pg = {$urandom, $urandom};
        if (mode == 0) begin
            for (int i = 0; i < 3; i++) pa[16*i +: 16] = 16'($urandom_range(0, 3000) - 1500);
            pa[15:0] += 16'(2511);
            sa = near_axes(pa, $urandom_range(0, 1) ? 400 : 2000);
            sg = near_axes(pg, $urandom_range(0, 1) ? 100 : 800);
        end else begin
            sa = {$urandom, $urandom};
            sg = {$urandom, $urandom};
        end
        clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 150);
        send_pair(pa, pg, sa, sg, $urandom_range(0, 7) != 0, $urandom_range(0, 1),
                  $urandom_range(0, 7) != 0, $urandom_range(0, 1), clock_ms);
    endtask

    initial begin
        logic [47:0] g;
        repeat (12) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        g = {16'sd0, 16'sd0, 16'd2511};
        write_reg(REG_INTERVAL, 0);
        write_reg(REG_FAIL_LIMIT, 0);
        send_pair(g, '0, g, '0, 1, 1, 1, 1, 0);
        send_pair({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h8000}}, 1, 1, 1, 0, 1);
        send_pair({3{16'h8000}}, '1, g, '0, 1, 0, 1, 1, 2);
        send_pair(g, 48'h1234, g, 48'h1234, 0, 1, 1, 1, 3);
        send_pair(g, 48'h1, g, 48'h2, 1, 1, 0, 1, 4);
        send_pair(g, '1, '1, '1, 0, 1, 0, 1, 5);
        send_pair({3{16'h0100}}, 0, {3{16'h0100}}, 0, 1, 1, 1, 1, 32'hffff_fff0);
        send_pair(g, 0, {16'd0, 16'd0, 16'd2400}, 48'h8000_0000, 1, 1, 1, 1, 32'h0000_0010);
        drain();
        write_reg(REG_PRI_PRESENT, 0);
        send_pair(g, 0, g, 1, 1, 1, 1, 1, 20);
        send_pair(g, 0, g, 1, 1, 1, 0, 1, 21);
        drain();
        write_reg(REG_SEC_PRESENT, 0);
        send_pair(g, 0, g, 1, 1, 1, 1, 1, 22);
        drain();
        write_reg(REG_PRI_PRESENT, 1);
        write_reg(REG_SEC_PRESENT, 1);
        write_reg(REG_ACCEL_THR, 16'hffff);
        write_reg(REG_GYRO_THR, 16'hffff);
        send_pair('1, '1, '0, '0, 1, 1, 1, 1, 40);
        drain();
        write_reg(REG_ACCEL_THR, 0);
        write_reg(REG_GYRO_THR, 0);
        write_reg(REG_FAIL_LIMIT, 255);
        write_reg(REG_GRAVITY, 16'hffff);
        send_pair(g, g, g, g, 1, 1, 1, 1, 50);
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_ACCEL_THR, phase == 3 ? 16'hffff : 16'($urandom_range(100, 900)));
            write_reg(REG_GYRO_THR, phase == 2 ? 16'd0 : 16'($urandom_range(50, 300)));
            write_reg(REG_INTERVAL, phase == 1 ? 16'hffff : 16'($urandom_range(0, 120)));
            write_reg(REG_FAIL_LIMIT, 8'($urandom_range(0, 6)));
            write_reg(REG_GRAVITY, phase == 0 ? 16'd0 : 16'($urandom_range(2000, 3000)));
            write_reg(REG_PRI_PRESENT, phase != 2 || $urandom_range(0, 1));
            write_reg(REG_SEC_PRESENT, 1);
            for (int n = 0; n < 60; n++) begin
                if (phase == 1 && n == 50) hold_off = 400;
                repeat ($urandom_range(1, 12)) random_pair($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 2) == 0) idle_gap();
            end
            drain();
        end
        $display("Sent %0d sample pairs: %0d cross checks, %0d reselections.",
                 sent, checks_seen, reselects_seen);
        if (fail_count == 0)
            $display("dual_imu_cross_check_selector_core_tb OK");
        else
            $display("dual_imu_cross_check_selector_core_tb NOT OK");
        $finish;
    end
endmodule
